### rtl/core/cluster_box_pool_manager_assert.svh
// assertion macros for the box pool manager
`ifndef CLUSTER_BOX_POOL_MANAGER_ASSERT_SVH
`define CLUSTER_BOX_POOL_MANAGER_ASSERT_SVH
`ifndef ASSERT_OFF
`define CBP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define CBP_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define CBP_ASSERT(label, clk, rst, prop)
`define CBP_ASSERT_NORST(label, clk, prop)
`endif
`endif

### rtl/core/cbpm_pkg.sv
package cbpm_pkg;
   localparam int NumBoxes = 64;
   localparam int IdW = $clog2(NumBoxes);
   localparam int LinkW = IdW + 1;
   localparam logic [LinkW-1:0] NilBox = LinkW'(NumBoxes);

   typedef enum logic [2:0] {
      KIND_ALLOC = 3'd0, KIND_ENQ = 3'd1, KIND_REL = 3'd2,
      KIND_UPD = 3'd3, KIND_CHK = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_UNQUEUED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_RD, S_EXEC, S_NB1, S_NB2, S_CLEAR
   } state_type;

   typedef struct packed {
      logic [11:0] lo_strip;
      logic [11:0] hi_strip;
      logic [31:0] lo_time;
      logic [31:0] hi_time;
      logic [31:0] charge_sum;
      logic [9:0]  peak;
   } stats_type;

   typedef struct packed {
      logic [LinkW-1:0] older;
      logic [LinkW-1:0] newer;
      logic             queued;
   } link_type;

   localparam stats_type StatsReset = '{
      lo_strip: '1, hi_strip: '0, lo_time: '1, hi_time: '0,
      charge_sum: '0, peak: '0};
endpackage

### rtl/core/cbpm_stats_mem.sv
module cbpm_stats_mem (
   input  logic                  clock,
   input  logic                  we,
   input  logic [cbpm_pkg::IdW-1:0] waddr,
   input  cbpm_pkg::stats_type   wdata,
   input  logic [cbpm_pkg::IdW-1:0] raddr,
   output cbpm_pkg::stats_type   rdata
);
   import cbpm_pkg::*;
   stats_type mem [NumBoxes];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

### rtl/core/cluster_box_pool_manager.sv
// box pool manager: free stack plus age-ordered doubly linked queue
// req_ channel: start with req_kind/box_id/hit_* is taken at an edge when busy is low.
// rsp_ channel: rsp_valid strobes one cycle with all result fields; no stall.
// the strobe follows the accepting edge after the memory read, execute,
// first and second neighbor link update states; busy is high through those
// states and low again in the strobe cycle, so a new start is taken at the edge
// that ends it; a new transaction is not taken while the last one is in flight.
// state lives in two memories with registered reads: link memory and
// stats memory. an enqueue or release writes its own link entry in the execute
// cycle and then updates up to two neighbor entries, each read on the
// single link memory read port in the state before its write.
// after reset the block runs a clearing pass that rewrites all 64 link and
// stats entries; busy is high during it. csr_ writes are taken anytime.
// csr_wr_data loads the time gap limit used by check, reset value 30.
module cluster_box_pool_manager (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_kind,
   input  logic [5:0]  req_box_id,
   input  logic [31:0] req_hit_time,
   input  logic [11:0] req_hit_strip,
   input  logic [9:0]  req_hit_charge,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_result_box,
   output logic        rsp_too_far,
   output logic [11:0] rsp_low_strip,
   output logic [11:0] rsp_high_strip,
   output logic [31:0] rsp_low_time,
   output logic [31:0] rsp_high_time,
   output logic [31:0] rsp_charge_total,
   output logic [9:0]  rsp_peak_charge,
   output logic [6:0]  rsp_newer_box,
   output logic [6:0]  rsp_oldest_box
);
   import cbpm_pkg::*;

   state_type state_ff, state_in;
   logic [31:0] limit_ff;
   logic [IdW:0] clr_ff, clr_in;
   logic [2:0] kind_ff, kind_in;
   logic [IdW-1:0] box_ff, box_in;
   logic [31:0] t_ff, t_in;
   logic [11:0] strip_ff, strip_in;
   logic [9:0] charge_ff, charge_in;
   logic [LinkW-1:0] free_ff, free_in, head_ff, head_in, tail_ff, tail_in;
   // pending neighbor writes
   logic nb1_en_ff, nb1_en_in, nb2_en_ff, nb2_en_in;
   logic [IdW-1:0] nb1_addr_ff, nb1_addr_in, nb2_addr_ff, nb2_addr_in;
   logic nb1_older_ff, nb1_older_in, nb2_older_ff, nb2_older_in;
   logic [LinkW-1:0] nb1_val_ff, nb1_val_in, nb2_val_ff, nb2_val_in;

   link_type lmem [NumBoxes];
   link_type lrd;
   logic [IdW-1:0] lraddr;
   logic lwe;
   logic [IdW-1:0] lwaddr;
   link_type lwdata;

   always_ff @(posedge clock) begin
      if (lwe) lmem[lwaddr] <= lwdata;
      lrd <= lmem[lraddr];
   end

   stats_type srd, swdata;
   logic swe;
   logic [IdW-1:0] swaddr;

   cbpm_stats_mem u_stats (
      .clock(clock), .we(swe), .waddr(swaddr), .wdata(swdata),
      .raddr(box_in), .rdata(srd));

   stats_type upd;
   logic [32:0] sum;
   logic [31:0] gap;
   link_type own;
   status_type st_ff, st_in;
   logic far_ff, far_in;
   stats_type ostat_ff, ostat_in;
   logic [LinkW-1:0] onewer_ff, onewer_in;
   logic [IdW-1:0] obox_ff, obox_in;
   logic vld_ff, vld_in;

   always_comb begin
      sum = {1'b0, srd.charge_sum} + 33'(charge_ff);
      upd = srd;
      if (t_ff < srd.lo_time) upd.lo_time = t_ff;
      if (t_ff > srd.hi_time) upd.hi_time = t_ff;
      if (strip_ff < srd.lo_strip) upd.lo_strip = strip_ff;
      if (strip_ff > srd.hi_strip) upd.hi_strip = strip_ff;
      upd.charge_sum = sum[32] ? '1 : sum[31:0];
      if (charge_ff > srd.peak) upd.peak = charge_ff;
      gap = (t_ff >= srd.hi_time) ? t_ff - srd.hi_time : srd.hi_time - t_ff;
   end

   always_comb begin
      state_in = state_ff; clr_in = clr_ff;
      kind_in = kind_ff; box_in = box_ff; t_in = t_ff; strip_in = strip_ff;
      charge_in = charge_ff;
      free_in = free_ff; head_in = head_ff; tail_in = tail_ff;
      nb1_en_in = nb1_en_ff; nb1_addr_in = nb1_addr_ff; nb1_older_in = nb1_older_ff;
      nb1_val_in = nb1_val_ff;
      nb2_en_in = nb2_en_ff; nb2_addr_in = nb2_addr_ff; nb2_older_in = nb2_older_ff;
      nb2_val_in = nb2_val_ff;
      st_in = st_ff; far_in = far_ff; ostat_in = ostat_ff; onewer_in = onewer_ff;
      obox_in = obox_ff; vld_in = 1'b0;
      lraddr = box_ff; lwe = 1'b0; lwaddr = box_ff; lwdata = '0;
      swe = 1'b0; swaddr = box_ff; swdata = StatsReset;
      own = lrd;
      busy = (state_ff != S_IDLE);
      case (state_ff)
         S_CLEAR: begin
            lwe = 1'b1; lwaddr = clr_ff[IdW-1:0];
            lwdata.older = (clr_ff == '0) ? NilBox : LinkW'(clr_ff - 1'b1);
            lwdata.newer = NilBox; lwdata.queued = 1'b0;
            swe = 1'b1; swaddr = clr_ff[IdW-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (IdW+1)'(NumBoxes - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               kind_in = req_kind; t_in = req_hit_time; strip_in = req_hit_strip;
               charge_in = req_hit_charge;
               box_in = req_box_id;
               if (req_kind == KIND_ALLOC && free_ff != NilBox) box_in = free_ff[IdW-1:0];
               state_in = S_RD;
            end
         end
         S_RD: begin
            lraddr = box_ff; state_in = S_EXEC;
         end
         S_EXEC: begin
            nb1_en_in = 1'b0; nb2_en_in = 1'b0;
            st_in = ST_OK; far_in = 1'b0; obox_in = box_ff;
            ostat_in = srd; onewer_in = lrd.newer;
            state_in = S_NB1;
            case (kind_type'(kind_ff))
               KIND_ALLOC: begin
                  if (free_ff == NilBox) begin
                     st_in = ST_EMPTY; obox_in = '0; ostat_in = '0; onewer_in = NilBox;
                  end else begin
                     free_in = (lrd.older < NilBox) ? lrd.older : NilBox;
                  end
               end
               KIND_ENQ: begin
                  if (!lrd.queued) begin
                     own.queued = 1'b1; own.newer = NilBox;
                     if (head_ff < NilBox) begin
                        own.older = head_ff;
                        nb1_en_in = 1'b1; nb1_addr_in = head_ff[IdW-1:0];
                        nb1_older_in = 1'b0; nb1_val_in = LinkW'(box_ff);
                     end else begin
                        own.older = NilBox; tail_in = LinkW'(box_ff);
                     end
                     head_in = LinkW'(box_ff);
                     lwe = 1'b1; lwdata = own; onewer_in = NilBox;
                  end
               end
               KIND_REL: begin
                  if (!lrd.queued) st_in = ST_UNQUEUED;
                  else begin
                     if (LinkW'(box_ff) != head_ff && LinkW'(box_ff) != tail_ff) begin
                        nb1_en_in = lrd.newer < NilBox; nb1_addr_in = lrd.newer[IdW-1:0];
                        nb1_older_in = 1'b1; nb1_val_in = lrd.older;
                        nb2_en_in = lrd.older < NilBox; nb2_addr_in = lrd.older[IdW-1:0];
                        nb2_older_in = 1'b0; nb2_val_in = lrd.newer;
                     end else begin
                        if (LinkW'(box_ff) == head_ff) begin
                           head_in = (lrd.older < NilBox) ? lrd.older : NilBox;
                           nb1_en_in = lrd.older < NilBox; nb1_addr_in = lrd.older[IdW-1:0];
                           nb1_older_in = 1'b0; nb1_val_in = NilBox;
                        end
                        if (LinkW'(box_ff) == tail_ff) begin
                           tail_in = (lrd.newer < NilBox) ? lrd.newer : NilBox;
                           nb2_en_in = lrd.newer < NilBox; nb2_addr_in = lrd.newer[IdW-1:0];
                           nb2_older_in = 1'b1; nb2_val_in = NilBox;
                        end
                     end
                     own.queued = 1'b0; own.newer = NilBox; own.older = free_ff;
                     free_in = LinkW'(box_ff);
                     lwe = 1'b1; lwdata = own;
                     swe = 1'b1; ostat_in = StatsReset; onewer_in = NilBox;
                  end
               end
               KIND_UPD: begin
                  swe = 1'b1; swdata = upd; ostat_in = upd;
               end
               KIND_CHK: far_in = gap > limit_ff;
               default: ;
            endcase
            // first neighbor entry is read while the own entry is written
            lraddr = nb1_addr_in;
         end
         S_NB1: begin
            lraddr = nb2_addr_ff;
            lwe = nb1_en_ff; lwaddr = nb1_addr_ff; lwdata = lrd;
            if (nb1_older_ff) lwdata.older = nb1_val_ff; else lwdata.newer = nb1_val_ff;
            state_in = S_NB2;
         end
         S_NB2: begin
            lwe = nb2_en_ff; lwaddr = nb2_addr_ff; lwdata = lrd;
            if (nb2_older_ff) lwdata.older = nb2_val_ff; else lwdata.newer = nb2_val_ff;
            // enqueue onto the old head can touch the own box entry only if
            // the box is its own head, which the queued guard excludes
            if (nb2_en_ff && nb2_addr_ff == obox_ff) onewer_in = lwdata.newer;
            vld_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_NB1 && nb1_en_ff && nb1_addr_ff == obox_ff && !nb1_older_ff)
         onewer_in = nb1_val_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; limit_ff <= 32'd30;
         free_ff <= LinkW'(NumBoxes - 1); head_ff <= NilBox; tail_ff <= NilBox;
         vld_ff <= 1'b0; nb1_en_ff <= 1'b0; nb2_en_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in;
         if (csr_wr_en) limit_ff <= csr_wr_data;
         free_ff <= free_in; head_ff <= head_in; tail_ff <= tail_in;
         vld_ff <= vld_in; nb1_en_ff <= nb1_en_in; nb2_en_ff <= nb2_en_in;
      end
      kind_ff <= kind_in; box_ff <= box_in; t_ff <= t_in; strip_ff <= strip_in;
      charge_ff <= charge_in;
      nb1_addr_ff <= nb1_addr_in; nb1_older_ff <= nb1_older_in; nb1_val_ff <= nb1_val_in;
      nb2_addr_ff <= nb2_addr_in; nb2_older_ff <= nb2_older_in; nb2_val_ff <= nb2_val_in;
      st_ff <= st_in; far_ff <= far_in; ostat_ff <= ostat_in; onewer_ff <= onewer_in;
      obox_ff <= obox_in;
   end

   assign rsp_valid = vld_ff;
   assign rsp_status = st_ff;
   assign rsp_result_box = obox_ff;
   assign rsp_too_far = far_ff;
   assign rsp_low_strip = ostat_ff.lo_strip;
   assign rsp_high_strip = ostat_ff.hi_strip;
   assign rsp_low_time = ostat_ff.lo_time;
   assign rsp_high_time = ostat_ff.hi_time;
   assign rsp_charge_total = ostat_ff.charge_sum;
   assign rsp_peak_charge = ostat_ff.peak;
   assign rsp_newer_box = onewer_ff;
   assign rsp_oldest_box = tail_ff;

`include "cluster_box_pool_manager_assert.svh"
   `CBP_ASSERT(a_strobe_busy, clock, reset, rsp_valid |-> !busy)
   `CBP_ASSERT(a_start_busy, clock, reset, (start && !busy) |=> busy)
   `CBP_ASSERT(a_tail_head, clock, reset, (head_ff == NilBox) |-> (tail_ff == NilBox))
endmodule
